>>> rtl/zga_pkg.sv
// ----------------------------------------------------------------------------
// zga_pkg: shared types and constants
// Angle table, zone codes and register indexes for the goal approach block.
// ----------------------------------------------------------------------------
package zga_pkg;

	localparam int ANG_FRAC  = 30;
	localparam int MAX_STEPS = 24;
	localparam int AW        = 36;   // angle width, covers +-2*pi at 30 fraction bits
	localparam int XW        = 36;   // CORDIC datapath width

	localparam logic signed [AW-1:0] PI_A      = 36'sd3373259426;
	localparam logic signed [AW-1:0] HALF_PI_A = 36'sd1686629713;
	localparam logic signed [AW-1:0] TWO_PI_A  = 36'sd6746518852;
	localparam logic [29:0]          GAIN_INV  = 30'd652032874;
	localparam logic signed [XW-1:0] OUT_LIM   = 36'sd65535;

	typedef enum logic [2:0] {
		ZONE_IDLE  = 3'd0,
		ZONE_STOP  = 3'd1,
		ZONE_CREEP = 3'd2,
		ZONE_DECEL = 3'd3,
		ZONE_ACCEL = 3'd4
	} zone_t;

	typedef enum logic [2:0] {
		REG_MAX_SPEED    = 3'd0,
		REG_ACCEL_STEP   = 3'd1,
		REG_STOP_RADIUS  = 3'd2,
		REG_CREEP_RADIUS = 3'd3,
		REG_DECEL_RADIUS = 3'd4,
		REG_CREEP_SPEED  = 3'd5,
		REG_FLOOR_SPEED  = 3'd6,
		REG_IDLE_GOAL    = 3'd7
	} reg_idx_t;

	// arctangent of 2^-i, 30 fraction bits
	function automatic logic signed [AW-1:0] atan_lut(input logic [4:0] i);
		logic signed [AW-1:0] v;
		begin
			unique case (i)
				5'd0:  v = 36'sd843314857;
				5'd1:  v = 36'sd497837829;
				5'd2:  v = 36'sd263043837;
				5'd3:  v = 36'sd133525159;
				5'd4:  v = 36'sd67021687;
				5'd5:  v = 36'sd33543516;
				5'd6:  v = 36'sd16775851;
				5'd7:  v = 36'sd8388437;
				5'd8:  v = 36'sd4194283;
				5'd9:  v = 36'sd2097149;
				5'd10: v = 36'sd1048576;
				5'd11: v = 36'sd524288;
				5'd12: v = 36'sd262144;
				5'd13: v = 36'sd131072;
				5'd14: v = 36'sd65536;
				5'd15: v = 36'sd32768;
				5'd16: v = 36'sd16384;
				5'd17: v = 36'sd8192;
				5'd18: v = 36'sd4096;
				5'd19: v = 36'sd2048;
				5'd20: v = 36'sd1024;
				5'd21: v = 36'sd512;
				5'd22: v = 36'sd256;
				5'd23: v = 36'sd128;
				default: v = '0;
			endcase
			return v;
		end
	endfunction

endpackage

>>> rtl/zga_cordic.sv
// ----------------------------------------------------------------------------
// zga_cordic: shared CORDIC step unit
// One micro-rotation per cycle, vectoring or rotation mode, one step count.
// ----------------------------------------------------------------------------
module zga_cordic #(
	parameter int STEPS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          vec_mode,
	input  logic signed [zga_pkg::XW-1:0] x_in,
	input  logic signed [zga_pkg::XW-1:0] y_in,
	input  logic signed [zga_pkg::AW-1:0] z_in,
	output logic                          done,
	output logic signed [zga_pkg::XW-1:0] x_out,
	output logic signed [zga_pkg::XW-1:0] y_out,
	output logic signed [zga_pkg::AW-1:0] z_out
);
	import zga_pkg::*;

	localparam int NSTEP = (STEPS < MAX_STEPS) ? STEPS : MAX_STEPS;

	logic               busy_q;
	logic               mode_q;
	logic [4:0]         idx_q;
	logic signed [XW-1:0] x_q, y_q;
	logic signed [AW-1:0] z_q;
	logic               up;
	logic signed [XW-1:0] xs, ys;

	// direction: vectoring drives y to zero, rotation drives z to zero
	assign up = mode_q ? (y_q >= 0) : (z_q >= 0);
	assign xs = x_q >>> idx_q;
	assign ys = y_q >>> idx_q;

	// advance one step per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (busy_q) begin
				if (idx_q == 5'(NSTEP - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				idx_q <= idx_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mode_q <= vec_mode;
			x_q    <= x_in;
			y_q    <= y_in;
			z_q    <= z_in;
		end else if (busy_q) begin
			if (mode_q) begin
				if (up) begin
					x_q <= x_q + ys; y_q <= y_q - xs; z_q <= z_q + atan_lut(idx_q);
				end else begin
					x_q <= x_q - ys; y_q <= y_q + xs; z_q <= z_q - atan_lut(idx_q);
				end
			end else begin
				if (up) begin
					x_q <= x_q - ys; y_q <= y_q + xs; z_q <= z_q - atan_lut(idx_q);
				end else begin
					x_q <= x_q + ys; y_q <= y_q - xs; z_q <= z_q + atan_lut(idx_q);
				end
			end
		end
	end

	assign x_out = x_q;
	assign y_out = y_q;
	assign z_out = z_q;

endmodule

>>> rtl/zoned_goal_approach_with_rotation_unit.sv
// ----------------------------------------------------------------------------
// zoned_goal_approach_with_rotation_unit: zoned approach speed with rotation
// Distance and bearing by vectoring CORDIC, zone pick, ramp update, rotation.
// ----------------------------------------------------------------------------
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall  | cur_x cur_y cur_theta goal_x goal_y
// out     | output    | out_valid/out_stall| body_vx body_vy zone
// cfg     | input     | APB psel/penable   | eight registers, 32-bit words at 4*i
//
// A moving item runs the shared CORDIC unit for vectoring, then rotation (the
// step count N is CORDIC_STEPS, capped at 24), before out_valid rises; stopped
// items skip the rotation and idle goal items go straight to the output
// state. A new item is taken only after the last result has left the output
// register. Reset loads register defaults and clears the ramp speed.
// The result sits in an output register; in_stall stays high until it is taken.
module zoned_goal_approach_with_rotation_unit #(
	parameter int FRAC_BITS    = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [31:0]  cur_x,
	input  logic signed [31:0]  cur_y,
	input  logic signed [FRAC_BITS+2:0] cur_theta,
	input  logic signed [31:0]  goal_x,
	input  logic signed [31:0]  goal_y,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [16:0]  body_vx,
	output logic signed [16:0]  body_vy,
	output logic [2:0]          zone,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import zga_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b00000001,
		S_VEC   = 8'b00000010,
		S_WVEC  = 8'b00000100,
		S_SCALE = 8'b00001000,
		S_ZONE  = 8'b00010000,
		S_ANG   = 8'b00100000,
		S_WROT  = 8'b01000000,
		S_OUT   = 8'b10000000
	} state_t;

	state_t state_q;

	logic [15:0] max_speed_q, accel_step_q, creep_speed_q, floor_speed_q;
	logic [19:0] stop_radius_q, creep_radius_q, decel_radius_q;
	logic [31:0] idle_goal_q;
	logic [15:0] ramp_q, speed_q;
	logic signed [32:0] dx_q, dy_q;
	logic signed [AW-1:0] theta_q, th_q, t_q;
	logic signed [XW-1:0] dist_q;
	logic        neg_q, out_valid_q;
	logic [2:0]  zone_q;
	logic signed [16:0] vx_q, vy_q;

	// shared unit and its inputs
	logic                 c_start, c_vec, c_done;
	logic signed [XW-1:0] c_xin, c_yin, c_xo, c_yo;
	logic signed [AW-1:0] c_zin, c_zo;

	zga_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(c_start), .vec_mode(c_vec),
		.x_in(c_xin), .y_in(c_yin), .z_in(c_zin), .done(c_done),
		.x_out(c_xo), .y_out(c_yo), .z_out(c_zo)
	);

	// config port
	logic wr_en;
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_comb begin
		unique case (reg_idx_t'(paddr[4:2]))
			REG_MAX_SPEED:    prdata = {16'd0, max_speed_q};
			REG_ACCEL_STEP:   prdata = {16'd0, accel_step_q};
			REG_STOP_RADIUS:  prdata = {12'd0, stop_radius_q};
			REG_CREEP_RADIUS: prdata = {12'd0, creep_radius_q};
			REG_DECEL_RADIUS: prdata = {12'd0, decel_radius_q};
			REG_CREEP_SPEED:  prdata = {16'd0, creep_speed_q};
			REG_FLOOR_SPEED:  prdata = {16'd0, floor_speed_q};
			REG_IDLE_GOAL:    prdata = idle_goal_q;
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q    <= 16'd6390;
			accel_step_q   <= 16'd64;
			stop_radius_q  <= 20'd328;
			creep_radius_q <= 20'd1311;
			decel_radius_q <= 20'd3195;
			creep_speed_q  <= 16'd655;
			floor_speed_q  <= 16'd655;
			idle_goal_q    <= 32'd655360000;
		end else if (wr_en) begin
			unique case (reg_idx_t'(paddr[4:2]))
				REG_MAX_SPEED:    max_speed_q    <= pwdata[15:0];
				REG_ACCEL_STEP:   accel_step_q   <= pwdata[15:0];
				REG_STOP_RADIUS:  stop_radius_q  <= pwdata[19:0];
				REG_CREEP_RADIUS: creep_radius_q <= pwdata[19:0];
				REG_DECEL_RADIUS: decel_radius_q <= pwdata[19:0];
				REG_CREEP_SPEED:  creep_speed_q  <= pwdata[15:0];
				REG_FLOOR_SPEED:  floor_speed_q  <= pwdata[15:0];
				REG_IDLE_GOAL:    idle_goal_q    <= pwdata;
				default: ;
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE) || out_valid_q;
	assign out_valid = out_valid_q;
	assign body_vx   = vx_q;
	assign body_vy   = vy_q;
	assign zone      = zone_q;

	// K scaling: one 36x30 product, rounded
	logic signed [XW-1:0] k_in;
	logic signed [66:0]   k_prod;
	logic signed [XW-1:0] k_res;
	assign k_in   = (state_q == S_SCALE) ? c_xo : XW'($signed({1'b0, speed_q}));
	assign k_prod = 67'(k_in) * $signed({1'b0, GAIN_INV});
	assign k_res  = XW'((k_prod + (67'sd1 <<< (ANG_FRAC - 1))) >>> ANG_FRAC);

	// angle reduction: offset angle plus heading, wrap into +-pi
	logic signed [AW-1:0] t_sum, t_w;
	logic signed [AW:0]   t_ext;
	always_comb begin
		t_ext = (AW+1)'(c_zo) + ((AW+1)'(theta_q) <<< (ANG_FRAC - FRAC_BITS));
		// sum lies within (-3*pi, 3*pi) so one wrap suffices
		if (t_ext > (AW+1)'(PI_A))       t_sum = AW'(t_ext - (AW+1)'(TWO_PI_A));
		else if (t_ext < -(AW+1)'(PI_A)) t_sum = AW'(t_ext + (AW+1)'(TWO_PI_A));
		else                             t_sum = AW'(t_ext);
		t_w = t_sum;
	end

	// ramp update
	logic [16:0] ramp_up;
	logic [15:0] ramp_dn, ramp_dn_c, ramp_up_c;
	assign ramp_up   = {1'b0, ramp_q} + {1'b0, accel_step_q};
	assign ramp_up_c = (ramp_up > {1'b0, max_speed_q}) ? max_speed_q : ramp_up[15:0];
	assign ramp_dn   = (ramp_q > accel_step_q) ? ramp_q - accel_step_q : 16'd0;
	assign ramp_dn_c = (ramp_dn > max_speed_q) ? max_speed_q : ramp_dn;

	// input to the shared unit
	always_comb begin
		c_start = 1'b0;
		c_vec   = 1'b1;
		c_xin   = '0;
		c_yin   = '0;
		c_zin   = '0;
		if (state_q == S_VEC) begin
			c_start = 1'b1;
			if (dx_q < 0) begin
				c_xin = -XW'(dx_q);
				c_yin = -XW'(dy_q);
				c_zin = (dy_q >= 0) ? PI_A : -PI_A;
			end else begin
				c_xin = XW'(dx_q);
				c_yin = XW'(dy_q);
			end
		end else if (state_q == S_ANG) begin
			c_start = 1'b1;
			c_vec   = 1'b0;
			c_xin   = k_res;
			c_zin   = t_q;
		end
	end

	// saturate a result to the output range
	function automatic logic signed [16:0] sat(input logic signed [XW-1:0] v, input logic n);
		logic signed [XW-1:0] w;
		begin
			w = n ? -v : v;
			if (w > OUT_LIM)       return 17'sd65535;
			else if (w < -OUT_LIM) return -17'sd65535;
			else                   return w[16:0];
		end
	endfunction

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			ramp_q      <= '0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && !in_stall) begin
						if (goal_x == idle_goal_q && goal_y == idle_goal_q) begin
							zone_q <= ZONE_IDLE;
							vx_q   <= '0;
							vy_q   <= '0;
							state_q <= S_OUT;
						end else begin
							state_q <= S_VEC;
						end
					end
				end
				S_VEC:  state_q <= S_WVEC;
				S_WVEC: if (c_done) state_q <= S_SCALE;
				S_SCALE: begin
					dist_q  <= k_res;
					th_q    <= t_w;
					state_q <= S_ZONE;
				end
				S_ZONE: begin
					vx_q <= '0;
					vy_q <= '0;
					priority if (dist_q <= XW'($signed({1'b0, stop_radius_q}))) begin
						zone_q  <= ZONE_STOP;
						state_q <= S_OUT;
					end else if (dist_q <= XW'($signed({1'b0, creep_radius_q}))) begin
						zone_q  <= ZONE_CREEP;
						speed_q <= creep_speed_q;
						state_q <= S_ANG;
					end else if (dist_q <= XW'($signed({1'b0, decel_radius_q}))) begin
						zone_q  <= ZONE_DECEL;
						ramp_q  <= ramp_dn_c;
						speed_q <= (ramp_dn_c > floor_speed_q) ? ramp_dn_c : floor_speed_q;
						state_q <= S_ANG;
					end else begin
						zone_q  <= ZONE_ACCEL;
						ramp_q  <= ramp_up_c;
						speed_q <= ramp_up_c;
						state_q <= S_ANG;
					end
				end
				S_ANG:  state_q <= S_WROT;
				S_WROT: begin
					if (c_done) begin
						vx_q    <= sat(c_xo, neg_q);
						vy_q    <= sat(c_yo, neg_q);
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload captures
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid && !in_stall) begin
			dx_q    <= 33'(goal_x) - 33'(cur_x);
			dy_q    <= 33'(goal_y) - 33'(cur_y);
			theta_q <= AW'(cur_theta);
		end
		// fold the angle into +-pi/2 with a sign flip
		if (state_q == S_ZONE) begin
			if (th_q > HALF_PI_A) begin
				t_q <= th_q - PI_A; neg_q <= 1'b1;
			end else if (th_q < -HALF_PI_A) begin
				t_q <= th_q + PI_A; neg_q <= 1'b1;
			end else begin
				t_q <= th_q; neg_q <= 1'b0;
			end
		end
	end

endmodule
